// ===== hw/rtl/crs_pkg.sv =====
// ----------------------------------------------------------------------------
// crs_pkg: shared types and constants of the column run and stats scan
// Holds the field widths, the count saturation limit, the record slot codes
// and the struct that carries one item's pending records to the output.
// ----------------------------------------------------------------------------
`default_nettype none

package crs_pkg;

  localparam int unsigned VAL_W = 32;
  localparam int unsigned CNT_W = 17;

  // Largest column the counters must track; counts saturate at the smaller
  // of this and the largest value a count field can carry.
  localparam longint unsigned MAX_COLUMN = 64'd65536;
  localparam longint unsigned CNT_MAX    = (64'd1 << CNT_W) - 64'd1;
  localparam logic [CNT_W-1:0] COUNT_CAP =
    CNT_W'((MAX_COLUMN > CNT_MAX) ? CNT_MAX : MAX_COLUMN);
  localparam logic [CNT_W-1:0] COUNT_ONE = CNT_W'(1);

  // Record slots of one item, in emission order
  localparam int unsigned REC_CLOSE = 0;  // run closed by a value change
  localparam int unsigned REC_FIN   = 1;  // open run flushed at end of column
  localparam int unsigned REC_SUM   = 2;  // column summary
  localparam int unsigned REC_NUM   = 3;

  // Record kinds on the kind output
  localparam logic KIND_RUN     = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  // Records produced by one item
  typedef struct packed {
    logic [REC_NUM-1:0]      pend;
    logic signed [VAL_W-1:0] close_value;
    logic [CNT_W-1:0]        close_length;
    logic signed [VAL_W-1:0] fin_value;
    logic [CNT_W-1:0]        fin_length;
    logic [CNT_W-1:0]        run_total;
    logic [CNT_W-1:0]        null_total;
    logic signed [VAL_W-1:0] min_value;
    logic signed [VAL_W-1:0] max_value;
    logic                    ascending;
  } crs_bundle_t;

  // Saturating count increment
  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] c);
    return (c >= COUNT_CAP) ? COUNT_CAP : c + COUNT_ONE;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/crs_scan.sv =====
// ----------------------------------------------------------------------------
// crs_scan: run tracking and column statistics
// Keeps the open run, the counters and min/max/ascending state, updates them
// for each taken item and presents the records that item produces.
// ----------------------------------------------------------------------------
`default_nettype none

module crs_scan import crs_pkg::*; (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    take_i,
  input  wire logic signed [VAL_W-1:0] value_i,
  input  wire logic                    is_null_i,
  input  wire logic                    last_i,
  output crs_bundle_t                  bundle_o
);

  logic signed [VAL_W-1:0] open_value_q, open_value_d, upd_value;
  logic [CNT_W-1:0]        open_length_q, open_length_d, upd_length;
  logic [CNT_W-1:0]        runs_q, runs_d, upd_runs;
  logic [CNT_W-1:0]        nulls_q, nulls_d, upd_nulls;
  logic signed [VAL_W-1:0] low_q, low_d, upd_low;
  logic signed [VAL_W-1:0] high_q, high_d, upd_high;
  logic                    asc_q, asc_d, upd_asc;
  logic                    at_start_q, at_start_d, upd_start;
  logic                    closing;

  // Advance the run state for the presented item
  always_comb begin
    upd_value  = open_value_q;
    upd_length = open_length_q;
    upd_runs   = runs_q;
    upd_nulls  = nulls_q;
    upd_low    = low_q;
    upd_high   = high_q;
    upd_asc    = asc_q;
    upd_start  = at_start_q;
    closing    = 1'b0;
    if (at_start_q) begin
      // first element opens run one, null or not
      upd_value  = value_i;
      upd_length = COUNT_ONE;
      upd_runs   = COUNT_ONE;
      upd_nulls  = is_null_i ? COUNT_ONE : '0;
      upd_low    = value_i;
      upd_high   = value_i;
      upd_asc    = 1'b1;
      upd_start  = 1'b0;
    end else if (is_null_i) begin
      upd_nulls  = sat_inc(nulls_q);
      upd_length = sat_inc(open_length_q);
    end else if (value_i != open_value_q) begin
      // value change: close the open run and start a new one
      closing    = 1'b1;
      if (value_i < open_value_q) begin
        upd_asc = 1'b0;
      end
      if (value_i < low_q) begin
        upd_low = value_i;
      end
      if (value_i > high_q) begin
        upd_high = value_i;
      end
      upd_value  = value_i;
      upd_length = COUNT_ONE;
      upd_runs   = sat_inc(runs_q);
    end else begin
      upd_length = sat_inc(open_length_q);
    end
  end

  // Return to column start after the last element
  always_comb begin
    if (last_i) begin
      open_value_d  = '0;
      open_length_d = '0;
      runs_d        = '0;
      nulls_d       = '0;
      low_d         = '0;
      high_d        = '0;
      asc_d         = 1'b1;
      at_start_d    = 1'b1;
    end else begin
      open_value_d  = upd_value;
      open_length_d = upd_length;
      runs_d        = upd_runs;
      nulls_d       = upd_nulls;
      low_d         = upd_low;
      high_d        = upd_high;
      asc_d         = upd_asc;
      at_start_d    = upd_start;
    end
  end

  // Gather the records this item produces
  always_comb begin
    bundle_o.pend               = '0;
    bundle_o.pend[REC_CLOSE]    = closing;
    bundle_o.pend[REC_FIN]      = last_i;
    bundle_o.pend[REC_SUM]      = last_i;
    bundle_o.close_value        = open_value_q;
    bundle_o.close_length       = open_length_q;
    bundle_o.fin_value          = upd_value;
    bundle_o.fin_length         = upd_length;
    bundle_o.run_total          = upd_runs;
    bundle_o.null_total         = upd_nulls;
    bundle_o.min_value          = upd_low;
    bundle_o.max_value          = upd_high;
    bundle_o.ascending          = upd_asc;
  end

  // Hold state until an item is taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_value_q  <= '0;
      open_length_q <= '0;
      runs_q        <= '0;
      nulls_q       <= '0;
      low_q         <= '0;
      high_q        <= '0;
      asc_q         <= 1'b1;
      at_start_q    <= 1'b1;
    end else if (take_i) begin
      open_value_q  <= open_value_d;
      open_length_q <= open_length_d;
      runs_q        <= runs_d;
      nulls_q       <= nulls_d;
      low_q         <= low_d;
      high_q        <= high_d;
      asc_q         <= asc_d;
      at_start_q    <= at_start_d;
    end
  end

  // Assertions
  a_open_len_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !at_start_q |-> (open_length_q != '0) && (runs_q != '0))
    else $error("open run without length or run count");

  a_min_le_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    low_q <= high_q)
    else $error("min above max");

  a_open_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !at_start_q |-> (open_value_q >= low_q) && (open_value_q <= high_q))
    else $error("open run value outside min/max");

endmodule

`default_nettype wire

// ===== hw/rtl/column_run_and_stats_scan.sv =====
// ----------------------------------------------------------------------------
// column_run_and_stats_scan: run-length scan with column statistics
// Streams a column of signed 32-bit values with null flags and emits run
// records and one summary record per column.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries one column element per
//   transaction: value_i, is_null_i and last_i on the final element.
//   Output channel (out_valid_o / out_stall_i) carries one record per
//   transaction: kind_o selects run record or summary; final_res_o marks the
//   summary, the last record of a column.
//   An element produces zero to three records. They are registered in a
//   record bundle and appear in the cycle after the element is taken, one
//   per cycle while the receiver does not stall. The next element is taken
//   in the same cycle as the bundle's last record leaves, so elements with
//   at most one record flow at one per cycle without receiver stalls; an
//   element with more records holds the input until its last one leaves.
//   When the receiver stalls, the current record holds and the input stalls
//   once a bundle is waiting. Reset clears the pending records and returns
//   the scan to the start of a column; after the last element it returns there as well.
// ----------------------------------------------------------------------------
`default_nettype none

module column_run_and_stats_scan import crs_pkg::*; (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    in_valid_i,
  output      logic                    in_stall_o,
  input  wire logic signed [VAL_W-1:0] value_i,
  input  wire logic                    is_null_i,
  input  wire logic                    last_i,
  output      logic                    out_valid_o,
  input  wire logic                    out_stall_i,
  output      logic                    kind_o,
  output      logic signed [VAL_W-1:0] run_value_o,
  output      logic [CNT_W-1:0]        run_length_o,
  output      logic [CNT_W-1:0]        run_total_o,
  output      logic [CNT_W-1:0]        null_total_o,
  output      logic signed [VAL_W-1:0] min_value_o,
  output      logic signed [VAL_W-1:0] max_value_o,
  output      logic                    ascending_o,
  output      logic                    final_res_o
);

  crs_bundle_t        bundle_new;
  crs_bundle_t        bundle_q;
  logic [REC_NUM-1:0] pend_q, pend_d, pend_pop;
  logic               in_fire, out_fire;

  // Scan state and record generation
  crs_scan u_scan (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .take_i    (in_fire),
    .value_i   (value_i),
    .is_null_i (is_null_i),
    .last_i    (last_i),
    .bundle_o  (bundle_new)
  );

  // Handshake: drop the lowest pending record on each output transaction
  assign out_valid_o = |pend_q;
  assign out_fire    = out_valid_o && !out_stall_i;
  assign pend_pop    = out_fire ? (pend_q & (pend_q - REC_NUM'(1))) : pend_q;
  assign in_stall_o  = |pend_pop;
  assign in_fire     = in_valid_i && !in_stall_o;

  always_comb begin
    if (in_fire) begin
      pend_d = bundle_new.pend;
    end else begin
      pend_d = pend_pop;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else begin
      pend_q <= pend_d;
    end
  end

  // Load record payload with each accepted element
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      bundle_q <= bundle_new;
    end
  end

  // Select the current record for the output
  always_comb begin
    kind_o       = KIND_RUN;
    run_value_o  = '0;
    run_length_o = '0;
    run_total_o  = '0;
    null_total_o = '0;
    min_value_o  = '0;
    max_value_o  = '0;
    ascending_o  = 1'b0;
    final_res_o  = 1'b0;
    if (pend_q[REC_CLOSE]) begin
      run_value_o  = bundle_q.close_value;
      run_length_o = bundle_q.close_length;
    end else if (pend_q[REC_FIN]) begin
      run_value_o  = bundle_q.fin_value;
      run_length_o = bundle_q.fin_length;
    end else if (pend_q[REC_SUM]) begin
      kind_o       = KIND_SUMMARY;
      run_total_o  = bundle_q.run_total;
      null_total_o = bundle_q.null_total;
      min_value_o  = bundle_q.min_value;
      max_value_o  = bundle_q.max_value;
      ascending_o  = bundle_q.ascending;
      final_res_o  = 1'b1;
    end
  end

  // Assertions
  a_fin_with_sum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q[REC_FIN] |-> pend_q[REC_SUM])
    else $error("flushed run pending without its summary");

  a_last_loads_summary: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && last_i |=> pend_q[REC_FIN] && pend_q[REC_SUM])
    else $error("last element did not queue run and summary");

  a_summary_ends_bundle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_fire && final_res_o |-> $countones(pend_q) == 1)
    else $error("summary left before other records of its bundle");

  a_summary_counts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q[REC_SUM] |-> (bundle_q.run_total != '0) && (bundle_q.fin_length != '0))
    else $error("summary with empty run count");

endmodule

`default_nettype wire

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the column run and stats scan
// Feeds columns of signed values with null flags through the input channel,
// predicts every run and summary record in step with each accepted
// transaction, and checks the output records in order. Runs directed
// columns and random columns under four idling mixes with one long receiver
// hold-off.
// ----------------------------------------------------------------------------

module tb_top;
  import crs_pkg::*;

  localparam int unsigned HALF_PERIOD = 6;
  localparam int unsigned RESET_CYCLES = 12;
  localparam int unsigned HOLD_CYCLES = 400;
  localparam int unsigned DRAIN_CYCLES = 20;
  localparam int unsigned ITEMS_PER_PHASE = 34;
  localparam logic signed [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};
  localparam logic signed [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};

  typedef enum int {
    MODE_FREE,
    MODE_SEND_IDLE,
    MODE_RECV_STALL,
    MODE_BOTH_IDLE
  } idle_mode_e;

  typedef struct {
    logic signed [VAL_W-1:0] value;
    logic                    is_null;
    logic                    last;
  } element_t;

  typedef struct {
    logic                    kind;
    logic signed [VAL_W-1:0] run_value;
    logic [CNT_W-1:0]        run_length;
    logic [CNT_W-1:0]        run_total;
    logic [CNT_W-1:0]        null_total;
    logic signed [VAL_W-1:0] min_value;
    logic signed [VAL_W-1:0] max_value;
    logic                    ascending;
    logic                    final_res;
  } record_t;

  // DUT connections
  logic                    clk_i = 1'b0;
  logic                    rst_ni = 1'b0;
  logic                    in_valid_i = 1'b0;
  logic                    in_stall_o;
  logic signed [VAL_W-1:0] value_i = '0;
  logic                    is_null_i = 1'b0;
  logic                    last_i = 1'b0;
  logic                    out_valid_o;
  logic                    out_stall_i = 1'b0;
  logic                    kind_o;
  logic signed [VAL_W-1:0] run_value_o;
  logic [CNT_W-1:0]        run_length_o;
  logic [CNT_W-1:0]        run_total_o;
  logic [CNT_W-1:0]        null_total_o;
  logic signed [VAL_W-1:0] min_value_o;
  logic signed [VAL_W-1:0] max_value_o;
  logic                    ascending_o;
  logic                    final_res_o;

  // Stimulus and expectation stores
  element_t pending_elements[$];
  record_t  expected_records[$];
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned mismatches = 0;
  logic        hold_request = 1'b0;
  logic        hold_taken = 1'b0;
  int unsigned hold_left = 0;

  // Predicted scan state
  logic signed [VAL_W-1:0] cur_value = '0;
  logic [CNT_W-1:0]        cur_length = '0;
  logic [CNT_W-1:0]        runs_count = '0;
  logic [CNT_W-1:0]        nulls_count = '0;
  logic signed [VAL_W-1:0] lowest = '0;
  logic signed [VAL_W-1:0] highest = '0;
  logic                    rising = 1'b1;
  logic                    column_open = 1'b0;

  column_run_and_stats_scan dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .value_i      (value_i),
    .is_null_i    (is_null_i),
    .last_i       (last_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .kind_o       (kind_o),
    .run_value_o  (run_value_o),
    .run_length_o (run_length_o),
    .run_total_o  (run_total_o),
    .null_total_o (null_total_o),
    .min_value_o  (min_value_o),
    .max_value_o  (max_value_o),
    .ascending_o  (ascending_o),
    .final_res_o  (final_res_o)
  );

  always #HALF_PERIOD clk_i = ~clk_i;

  // Saturating count step
  function automatic logic [CNT_W-1:0] count_up(input logic [CNT_W-1:0] c);
    return (c >= COUNT_CAP) ? COUNT_CAP : c + CNT_W'(1);
  endfunction

  function automatic void push_run(input logic signed [VAL_W-1:0] v,
                                   input logic [CNT_W-1:0] len);
    record_t r;
    r = '{default: '0};
    r.kind = KIND_RUN;
    r.run_value = v;
    r.run_length = len;
    expected_records.push_back(r);
  endfunction

  // Advance the predicted scan by one element and queue its records
  function automatic void scan_element(input logic signed [VAL_W-1:0] v,
                                       input logic nul, input logic fin);
    record_t s;
    if (!column_open) begin
      cur_value = v;
      cur_length = count_up('0);
      runs_count = count_up('0);
      nulls_count = nul ? count_up('0) : '0;
      lowest = v;
      highest = v;
      rising = 1'b1;
      column_open = 1'b1;
    end else if (nul) begin
      nulls_count = count_up(nulls_count);
      cur_length = count_up(cur_length);
    end else if (v != cur_value) begin
      push_run(cur_value, cur_length);
      if (v < cur_value) rising = 1'b0;
      if (v < lowest) lowest = v;
      if (v > highest) highest = v;
      cur_value = v;
      cur_length = count_up('0);
      runs_count = count_up(runs_count);
    end else begin
      cur_length = count_up(cur_length);
    end
    // Flush the open run, then the column summary
    if (fin) begin
      push_run(cur_value, cur_length);
      s = '{default: '0};
      s.kind = KIND_SUMMARY;
      s.run_total = runs_count;
      s.null_total = nulls_count;
      s.min_value = lowest;
      s.max_value = highest;
      s.ascending = rising;
      s.final_res = 1'b1;
      expected_records.push_back(s);
      cur_value = '0;
      cur_length = '0;
      runs_count = '0;
      nulls_count = '0;
      lowest = '0;
      highest = '0;
      rising = 1'b1;
      column_open = 1'b0;
    end
  endfunction

  task automatic check_field(input string name, input logic signed [63:0] want,
                             input logic signed [63:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0d, actual %0d", name, want, got);
      mismatches++;
    end
  endtask

  function automatic void add_element(input logic signed [VAL_W-1:0] v,
                                      input logic nul, input logic fin);
    element_t e;
    e.value = v;
    e.is_null = nul;
    e.last = fin;
    pending_elements.push_back(e);
  endfunction

  // Mostly repeats and neighbors so runs form, with extremes and full range
  function automatic logic signed [VAL_W-1:0] pick_value(
      input logic signed [VAL_W-1:0] prev);
    case ($urandom_range(9))
      0, 1, 2: return prev;
      3:       return prev + 1;
      4:       return prev - 1;
      5:       return $urandom_range(1) ? VAL_MAX : VAL_MIN;
      default: return $urandom();
    endcase
  endfunction

  // Queue whole random columns until the phase has enough elements
  task automatic add_random_columns(input int unsigned count);
    int unsigned added;
    int unsigned len;
    logic signed [VAL_W-1:0] v;
    added = 0;
    v = $urandom();
    while (added < count) begin
      len = ($urandom_range(7) == 0) ? 1 : $urandom_range(12, 2);
      for (int unsigned k = 0; k < len; k++) begin
        v = pick_value(v);
        add_element(v, $urandom_range(3) == 0, k == len - 1);
      end
      added += len;
    end
  endtask

  // Driver: predict on acceptance, then offer the next element or idle
  always @(posedge clk_i) begin
    element_t e;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) scan_element(value_i, is_null_i, last_i);
      if (!in_valid_i || !in_stall_o) begin
        if (pending_elements.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          e = pending_elements.pop_front();
          in_valid_i <= 1'b1;
          value_i <= e.value;
          is_null_i <= e.is_null;
          last_i <= e.last;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Receiver: one long hold-off on request, random stalls otherwise
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (hold_request && !hold_taken) begin
        hold_taken <= 1'b1;
        hold_left <= HOLD_CYCLES;
        out_stall_i <= 1'b1;
      end else if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= ($urandom_range(99) < recv_stall_pct);
      end
    end
  end

  // Monitor: compare each record transaction with the oldest expectation
  always @(posedge clk_i) begin
    record_t r;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_records.size() == 0) begin
        $error("unexpected record: kind %0d run_value %0d", kind_o, run_value_o);
        mismatches++;
      end else begin
        r = expected_records.pop_front();
        check_field("kind", r.kind, kind_o);
        check_field("run_value", r.run_value, run_value_o);
        check_field("run_length", r.run_length, run_length_o);
        check_field("run_total", r.run_total, run_total_o);
        check_field("null_total", r.null_total, null_total_o);
        check_field("min_value", r.min_value, min_value_o);
        check_field("max_value", r.max_value, max_value_o);
        check_field("ascending", r.ascending, ascending_o);
        check_field("final_res", r.final_res, final_res_o);
      end
    end
  end

  // Watchdog
  initial begin
    #12_000_000;
    $display("tb_top: done, errors");
    $finish;
  end

  // Sequence reset, phases and end of run
  initial begin
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: single-element columns, one with a null first element
    add_element(VAL_MAX, 1'b0, 1'b1);
    add_element(VAL_MIN, 1'b1, 1'b1);
    // Null first element, extensions, changes down and up, extremes
    add_element(32'sd5, 1'b1, 1'b0);
    add_element(32'sd5, 1'b0, 1'b0);
    add_element(32'sd0, 1'b1, 1'b0);
    add_element(32'sd7, 1'b0, 1'b0);
    add_element(-32'sd3, 1'b0, 1'b0);
    add_element(VAL_MIN, 1'b0, 1'b0);
    add_element(VAL_MAX, 1'b0, 1'b0);
    add_element(VAL_MAX, 1'b0, 1'b0);
    add_element(32'sd123, 1'b1, 1'b1);
    // Non-decreasing column closed by a change on the last element
    add_element(-32'sd1, 1'b0, 1'b0);
    add_element(32'sd0, 1'b0, 1'b0);
    add_element(32'sd0, 1'b1, 1'b0);
    add_element(32'sd1, 1'b0, 1'b1);
    // Null values never enter the change test
    add_element(32'sd9, 1'b1, 1'b0);
    add_element(32'sd9, 1'b0, 1'b0);
    add_element(32'sd4, 1'b1, 1'b0);
    add_element(32'sd9, 1'b0, 1'b1);
    // Alternating bit patterns
    add_element(32'sh5555_5555, 1'b0, 1'b0);
    add_element(32'shAAAA_AAAA, 1'b0, 1'b1);

    // Random columns under each idling mix; hold off the receiver in the first
    for (int m = MODE_FREE; m <= MODE_BOTH_IDLE; m++) begin
      while (pending_elements.size() != 0) @(negedge clk_i);
      case (idle_mode_e'(m))
        MODE_FREE:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        MODE_SEND_IDLE:  begin send_idle_pct = 82; recv_stall_pct = 0;  end
        MODE_RECV_STALL: begin send_idle_pct = 0;  recv_stall_pct = 82; end
        default:         begin send_idle_pct = 11; recv_stall_pct = 11; end
      endcase
      add_random_columns(ITEMS_PER_PHASE);
      if (m == MODE_FREE) hold_request = 1'b1;
    end

    // Drain
    while (pending_elements.size() != 0 || in_valid_i) @(negedge clk_i);
    while (expected_records.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    if (mismatches == 0 && expected_records.size() == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/crs_pkg.sv
hw/rtl/crs_scan.sv
hw/rtl/column_run_and_stats_scan.sv
tb/sv/tb_top.sv
